FILE: hdl/deq_pkg.sv
package deq_pkg;

  // defaults for the top level parameters
  localparam int DEPTH_DEFAULT     = 256;
  localparam int WORD_BITS_DEFAULT = 32;

  // operation codes on func
  localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
  localparam logic [1:0] FUNC_PUSH_BACK  = 2'd1;
  localparam logic [1:0] FUNC_POP_FRONT  = 2'd2;
  localparam logic [1:0] FUNC_POP_BACK   = 2'd3;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RDWAIT = 5'b00010,
    ST_PREP   = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_OUT    = 5'b10000
  } deq_state_t;

endpackage

FILE: hdl/deq_ram.sv
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [WIDTH-1:0]     wdata,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/double_ended_queue_unit.sv
// double-ended queue of signed words held in a ring buffer ram
// a push runs ST_PREP, the divide and ST_OUT; an accepted pop first reads the ram in ST_RDWAIT;
//   an op that leaves the queue empty skips the divide, from ST_PREP to ST_OUT
// busy holds off a new operation until the last leaves ST_OUT; the pace is set by
//   the bit-serial restoring divider that forms the mean, one quotient bit a cycle
// reset: rst synchronous, clears front, count and sum; ram not cleared; done cannot stall
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int WORD_BITS = WORD_BITS_DEFAULT,
  parameter int CNT_BITS  = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func,
  input  logic signed [31:0]  push_value,
  output logic                done,
  output logic                ok,
  output logic signed [31:0]  popped_value,
  output logic [CNT_BITS-1:0] element_count,
  output logic                is_empty,
  output logic signed [31:0]  mean_value,
  output logic                mean_valid
);

  localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_BITS  = WORD_BITS + CNT_BITS;   // running sum never overflows
  localparam int ITER_BITS = $clog2(SUM_BITS);
  localparam int RING_BITS = CNT_BITS + 1;            // room for front + count

  deq_state_t state;

  // queue control state
  logic [IDX_BITS-1:0]        front;
  logic [CNT_BITS-1:0]        count;
  logic signed [SUM_BITS-1:0] sum;

  // per-operation result registers
  logic                 op_ok;
  logic [WORD_BITS-1:0] popped;

  // divider registers: dvd shifts the dividend out and the quotient in
  logic [SUM_BITS-1:0]  dvd;
  logic [CNT_BITS-1:0]  rem;
  logic [ITER_BITS-1:0] iter;
  logic                 neg;

  // ram port
  logic                 ram_we;
  logic [IDX_BITS-1:0]  ram_addr;
  logic [WORD_BITS-1:0] ram_rdata;

  // accept-cycle decode
  logic                 take;
  logic                 is_push;
  logic                 full;
  logic                 empty_now;
  logic [IDX_BITS-1:0]  front_dec;
  logic [IDX_BITS-1:0]  front_inc;
  logic [RING_BITS-1:0] back_raw;
  logic [RING_BITS-1:0] last_raw;
  logic [IDX_BITS-1:0]  back_pos;
  logic [IDX_BITS-1:0]  last_pos;
  logic [WORD_BITS-1:0] push_word;

  // divider step
  logic [CNT_BITS:0]    trial;
  logic [CNT_BITS:0]    diff;
  logic                 ge;
  logic [SUM_BITS-1:0]  quo_signed;
  logic [WORD_BITS-1:0] mean_word;

  assign take      = start && (state == ST_IDLE);
  assign is_push   = (func == FUNC_PUSH_FRONT) || (func == FUNC_PUSH_BACK);
  assign full      = (count == CNT_BITS'(DEPTH));
  assign empty_now = (count == '0);
  assign push_word = push_value[WORD_BITS-1:0];

  // ring arithmetic, a single compare and subtract covers any depth
  assign front_dec = (front == '0) ? IDX_BITS'(DEPTH - 1) : front - IDX_BITS'(1);
  assign front_inc = (front == IDX_BITS'(DEPTH - 1)) ? '0 : front + IDX_BITS'(1);

  always_comb begin
    back_raw = RING_BITS'(front) + RING_BITS'(count);
    if (back_raw >= RING_BITS'(DEPTH)) begin
      back_raw = back_raw - RING_BITS'(DEPTH);
    end
    last_raw = RING_BITS'(front) + RING_BITS'(count) - RING_BITS'(1);
    if (last_raw >= RING_BITS'(DEPTH)) begin
      last_raw = last_raw - RING_BITS'(DEPTH);
    end
  end

  assign back_pos = back_raw[IDX_BITS-1:0];
  assign last_pos = last_raw[IDX_BITS-1:0];

  // ram address follows the requested operation while idle
  always_comb begin
    unique case (func)
      FUNC_PUSH_FRONT: ram_addr = front_dec;
      FUNC_PUSH_BACK:  ram_addr = back_pos;
      FUNC_POP_FRONT:  ram_addr = front;
      FUNC_POP_BACK:   ram_addr = last_pos;
      default:         ram_addr = front;
    endcase
  end

  assign ram_we = take && is_push && !full;

  deq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH),
    .ADDR_BITS (IDX_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (push_word),
    .rdata (ram_rdata)
  );

  // restoring division step on the magnitude of the sum
  assign trial = {rem, dvd[SUM_BITS-1]};
  assign diff  = trial - {1'b0, count};
  assign ge    = (trial >= {1'b0, count});

  // quotient magnitude fits a word, restore the sign and truncate
  assign quo_signed = neg ? (~dvd + SUM_BITS'(1)) : dvd;
  assign mean_word  = quo_signed[WORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
      sum   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            popped <= '0;
            if (is_push) begin
              op_ok <= !full;
              state <= ST_PREP;
              if (!full) begin
                count <= count + CNT_BITS'(1);
                sum   <= sum + SUM_BITS'(signed'(push_word));
                if (func == FUNC_PUSH_FRONT) begin
                  front <= front_dec;
                end
              end
            end else begin
              op_ok <= !empty_now;
              if (!empty_now) begin
                // pop: data comes back from the ram next cycle
                count <= count - CNT_BITS'(1);
                state <= ST_RDWAIT;
                if (func == FUNC_POP_FRONT) begin
                  front <= front_inc;
                end
              end else begin
                state <= ST_PREP;
              end
            end
          end
        end
        ST_RDWAIT: begin
          popped <= ram_rdata;
          sum    <= sum - SUM_BITS'(signed'(ram_rdata));
          state  <= ST_PREP;
        end
        ST_PREP: begin
          neg   <= sum[SUM_BITS-1];
          dvd   <= sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
          rem   <= '0;
          iter  <= '0;
          // an empty queue has a zero sum, so dvd already reads as a zero mean
          state <= empty_now ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          rem  <= ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
          dvd  <= {dvd[SUM_BITS-2:0], ge};
          iter <= iter + ITER_BITS'(1);
          if (iter == ITER_BITS'(SUM_BITS - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result transfer is the single cycle spent in ST_OUT
  assign busy          = (state != ST_IDLE);
  assign done          = (state == ST_OUT);
  assign ok            = op_ok;
  assign popped_value  = 32'(signed'(popped));
  assign element_count = count;
  assign is_empty      = empty_now;
  assign mean_valid    = !empty_now;
  assign mean_value    = empty_now ? '0 : 32'(signed'(mean_word));

endmodule

FILE: test/tb_double_ended_queue_unit.sv
`timescale 1ns / 1ps

module tb_double_ended_queue_unit;
  import deq_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int WORD_BITS   = WORD_BITS_DEFAULT;
  localparam int CNT_BITS    = $clog2(DEPTH + 1);
  localparam int N_ITEMS     = 1200;
  // longest quiet stretch in a good run is one sender gap plus one divide
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 60;

  localparam logic signed [31:0] W_MIN = 32'h8000_0000;
  localparam logic signed [31:0] W_MAX = 32'h7fff_ffff;

  // value mixes used by the random episodes
  localparam int VAL_ALL_MIN = 0;
  localparam int VAL_ALL_MAX = 1;
  localparam int VAL_MIXED   = 2;

  // episode styles: grow toward full, random walk, shrink toward empty
  localparam int EP_FILL  = 0;
  localparam int EP_MIXED = 1;
  localparam int EP_DRAIN = 2;

  // one operation outcome as the block reports it
  typedef struct packed {
    logic                ok;
    logic signed [31:0]  popped;
    logic [CNT_BITS-1:0] count;
    logic                empty;
    logic signed [31:0]  mean;
    logic                mean_ok;
  } op_outcome_t;

  // one line of the directed stimulus, with an optional hand-written outcome
  typedef struct packed {
    logic [1:0]         f;
    logic signed [31:0] v;
    logic               typed;
    op_outcome_t        want;
  } op_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [1:0]          func = FUNC_PUSH_FRONT;
  logic signed [31:0]  push_value = '0;
  logic                busy;
  logic                done;
  logic                ok;
  logic signed [31:0]  popped_value;
  logic [CNT_BITS-1:0] element_count;
  logic                is_empty;
  logic signed [31:0]  mean_value;
  logic                mean_valid;

  double_ended_queue_unit #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .push_value   (push_value),
    .done         (done),
    .ok           (ok),
    .popped_value (popped_value),
    .element_count(element_count),
    .is_empty     (is_empty),
    .mean_value   (mean_value),
    .mean_valid   (mean_valid)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // shadow deque: ring of words, front position, fill level and running sum
  logic signed [31:0] ring_words [DEPTH];
  int unsigned        ring_front = 0;
  int unsigned        ring_held  = 0;
  longint             ring_sum   = 0;

  op_outcome_t op_outcomes [$];
  op_row_t     rows [$];

  int errors          = 0;
  int n_sent          = 0;
  int n_checked       = 0;
  int n_full_refused  = 0;
  int n_empty_refused = 0;
  int peak_held       = 0;
  int burst_left      = 1;
  int stall_cycles    = 0;
  op_outcome_t due;

  // applies one operation to the shadow deque and returns what the block must report
  function automatic op_outcome_t deque_apply(input logic [1:0] f,
                                              input logic signed [31:0] v);
    op_outcome_t        r;
    int unsigned        pos;
    logic signed [31:0] word;
    r = '0;
    if (f == FUNC_PUSH_FRONT || f == FUNC_PUSH_BACK) begin
      if (ring_held < DEPTH) begin
        if (f == FUNC_PUSH_FRONT) begin
          // front moves back one slot, wrapping below zero
          ring_front = (ring_front + DEPTH - 1) % DEPTH;
          pos = ring_front;
        end else begin
          pos = (ring_front + ring_held) % DEPTH;
        end
        ring_words[pos] = v;
        ring_held++;
        ring_sum += v;
        r.ok = 1'b1;
      end else begin
        n_full_refused++;
      end
    end else begin
      if (ring_held != 0) begin
        if (f == FUNC_POP_FRONT) begin
          pos = ring_front;
          ring_front = (ring_front + 1) % DEPTH;
        end else begin
          pos = (ring_front + ring_held - 1) % DEPTH;
        end
        word = ring_words[pos];
        ring_held--;
        ring_sum -= word;
        r.ok = 1'b1;
        r.popped = word;
      end else begin
        n_empty_refused++;
      end
    end
    if (ring_held > peak_held) peak_held = ring_held;
    r.count = ring_held[CNT_BITS-1:0];
    r.empty = (ring_held == 0);
    if (ring_held != 0) begin
      // longint division truncates toward zero, as the block must
      r.mean    = 32'(ring_sum / longint'(ring_held));
      r.mean_ok = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_word(input int kind);
    logic signed [31:0] w;
    case (kind)
      VAL_ALL_MIN: w = W_MIN;
      VAL_ALL_MAX: w = W_MAX;
      default: begin
        case ($urandom_range(0, 7))
          0:       w = W_MAX;
          1:       w = W_MIN;
          2:       w = '0;
          3:       w = -32'sd1;
          4:       w = 32'sd1;
          default: w = $urandom;
        endcase
      end
    endcase
    return w;
  endfunction

  task automatic add_row(input logic [1:0] f, input logic signed [31:0] v,
                         input logic typed, input logic r_ok,
                         input logic signed [31:0] r_pop, input int r_cnt,
                         input logic r_empty, input logic signed [31:0] r_mean,
                         input logic r_mean_ok);
    op_row_t w;
    w.f             = f;
    w.v             = v;
    w.typed         = typed;
    w.want.ok       = r_ok;
    w.want.popped   = r_pop;
    w.want.count    = r_cnt[CNT_BITS-1:0];
    w.want.empty    = r_empty;
    w.want.mean     = r_mean;
    w.want.mean_ok  = r_mean_ok;
    rows.push_back(w);
  endtask

  // offers one operation, waits for its transfer, files the outcome, then maybe idles
  task automatic issue_op(input logic [1:0] f, input logic signed [31:0] v,
                          input logic use_typed, input op_outcome_t typed);
    op_outcome_t r;
    int          gap;
    start      <= 1'b1;
    func       <= f;
    push_value <= v;
    // busy is read before this edge's updates land, so a low busy means transfer here
    do @(posedge clk); while (busy);
    r = deque_apply(f, v);
    if (use_typed) r = typed;
    op_outcomes.push_back(r);
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      // end of burst: drop start and sit out a gap that may end before, during or after the divide
      start <= 1'b0;
      gap = $urandom_range(1, 60);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic issue_random(input int bias, input int kind);
    logic [1:0] f;
    int         roll;
    roll = $urandom_range(0, 9);
    case (bias)
      EP_FILL:  f = (roll < 9) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
      EP_DRAIN: f = (roll < 9) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      default:  f = 2'($urandom_range(0, 3));
    endcase
    issue_op(f, rand_word(kind), 1'b0, '0);
  endtask

  // result check: every done strobe is one transfer, matched against the oldest outcome
  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (op_outcomes.size() == 0) begin
        $error("result transfer with no operation outstanding");
        errors++;
      end else begin
        due = op_outcomes.pop_front();
        check_field("ok", due.ok, ok);
        check_field("popped_value", due.popped, popped_value);
        check_field("element_count", due.count, element_count);
        check_field("is_empty", due.empty, is_empty);
        check_field("mean_value", due.mean, mean_value);
        check_field("mean_valid", due.mean_ok, mean_valid);
        n_checked++;
      end
    end
  end

  // watchdog: too long without any transfer on either side means a hang
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int ep;
    int mode;
    int kind;
    int extra;

    // directed rows: pops on empty, extremes at both ends, wrap of the front index,
    // a mean that rounds toward zero rather than down, then back to empty
    //      func             value        typed ok pop    cnt emp mean   valid
    add_row(FUNC_POP_FRONT,  '0,          1'b1, 0, '0,    0,  1,  '0,    0);
    add_row(FUNC_POP_BACK,   '0,          1'b1, 0, '0,    0,  1,  '0,    0);
    add_row(FUNC_PUSH_BACK,  W_MAX,       1'b1, 1, '0,    1,  0,  W_MAX, 1);
    add_row(FUNC_PUSH_FRONT, W_MIN,       1'b1, 1, '0,    2,  0,  '0,    1);
    add_row(FUNC_PUSH_BACK,  -32'sd1,     1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_PUSH_FRONT, '0,          1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_PUSH_BACK,  32'sd12345,  1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_POP_FRONT,  -32'sd5,     1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_POP_BACK,   W_MAX,       1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_POP_BACK,   '0,          1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_POP_FRONT,  '0,          1'b1, 1, W_MIN, 1,  0,  W_MAX, 1);
    add_row(FUNC_POP_BACK,   W_MIN,       1'b1, 1, W_MAX, 0,  1,  '0,    0);
    add_row(FUNC_POP_FRONT,  '0,          1'b1, 0, '0,    0,  1,  '0,    0);
    add_row(FUNC_PUSH_FRONT, -32'sd7,     1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_PUSH_FRONT, 32'sd3,      1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_PUSH_BACK,  '0,          1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_PUSH_BACK,  -32'sd3,     1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_POP_BACK,   '0,          1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_POP_FRONT,  '0,          1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_POP_FRONT,  '0,          1'b0, 0, '0,    0,  0,  '0,    0);
    add_row(FUNC_POP_BACK,   '0,          1'b0, 0, '0,    0,  0,  '0,    0);

    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) issue_op(rows[i].f, rows[i].v, rows[i].typed, rows[i].want);

    // random episodes: fill until the store refuses pushes, wander, drain until pops
    // are refused; the first fill uses only the most negative word, the second fill
    // only the most positive, so the mean hits both ends with a full store
    ep = 0;
    while (n_sent < N_ITEMS) begin
      mode = ep % 3;
      kind = (ep == 0) ? VAL_ALL_MIN : (ep == 3) ? VAL_ALL_MAX : VAL_MIXED;
      case (mode)
        EP_FILL: begin
          extra = $urandom_range(2, 6);
          while (extra != 0 && n_sent < N_ITEMS) begin
            issue_random(EP_FILL, kind);
            if (ring_held == DEPTH) extra--;
          end
        end
        EP_DRAIN: begin
          extra = $urandom_range(2, 6);
          while (extra != 0 && n_sent < N_ITEMS) begin
            issue_random(EP_DRAIN, kind);
            if (ring_held == 0) extra--;
          end
        end
        default: begin
          repeat ($urandom_range(20, 80)) issue_random(EP_MIXED, kind);
        end
      endcase
      ep++;
    end

    start <= 1'b0;
    while (op_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d deque operations sent, %0d outcomes compared, peak fill %0d of %0d",
             n_sent, n_checked, peak_held, DEPTH);
    $display("%0d pushes refused on a full store, %0d pops refused on an empty one",
             n_full_refused, n_empty_refused);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/double_ended_queue_unit.sv
test/tb_double_ended_queue_unit.sv
